FILE: hdl/rmt_pkg.sv
// Package for the region-of-interest motion tracker.
// Constants, payload types, controller/datapath command and status structs.
// No dependencies.
package rmt_pkg;

    localparam int MAX_CORNERS_DEF = 32;
    localparam int HISTORY_LEN_DEF = 10;

    localparam int COORD_W  = 16;
    localparam int POS_W    = 12;
    localparam int SIZE_W   = 11;
    localparam int IDX_W    = 5;
    localparam int SUM_W    = 22;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_START_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] cur_x;
        logic signed [COORD_W-1:0] cur_y;
        logic signed [COORD_W-1:0] prev_x;
        logic signed [COORD_W-1:0] prev_y;
        logic                      tracked;
        logic                      frame_end;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0]        corner_index;
        logic                    keep;
        logic signed [POS_W-1:0] region_x;
        logic signed [POS_W-1:0] region_y;
        logic                    moving;
        logic                    overflow;
        logic                    last;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic load;      // store and sum the input word
        logic div_start; // start both divisions
        logic update;    // apply mean, move region, record history
        logic emit_rd;   // read stored corner at emit pointer
        logic emit_adv;  // advance emit pointer
        logic clear;     // clear frame state
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
        logic emit_done;  // last stored corner has been read
        logic empty;      // no stored corners
    } t_sts;

endpackage

FILE: hdl/rmt_stream_if.sv
// Valid/ready channel carrying one payload word.
// Payload type is a parameter; no other dependencies.
interface rmt_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/roi_motion_tracker_update.sv
// Top level of the region-of-interest motion tracker.
// Depends on rmt_pkg, rmt_stream_if, rmt_ctrl, rmt_datapath.
//
// channel    dir  payload                                 handshake
// s_in       in   cur_x/y, prev_x/y, tracked, frame_end   valid/ready
// m_out      out  corner_index, keep, region_x/y, ...     valid/ready
// cfg        in   i_cfg_idx, i_cfg_data                   i_cfg_we
//
// On frame end the two serial dividers run side by side, one numerator bit
// at a time (27 by default); the first result word is offered after the
// division, the update and a corner read, then one result word per stored
// corner follows, one per cycle while the sink accepts.
// Input is not accepted during that walk; it reopens the cycle after the last.
// Reset is synchronous and clears all frame, accumulator and history state.
module roi_motion_tracker_update #(
    parameter int MAX_CORNERS = rmt_pkg::MAX_CORNERS_DEF,
    parameter int HISTORY_LEN = rmt_pkg::HISTORY_LEN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rmt_stream_if.sink                        s_in,
    rmt_stream_if.source                      m_out,
    input  logic                              i_cfg_we,
    input  logic [rmt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rmt_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import rmt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rmt_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_in.valid), .i_in_fend(s_in.data.frame_end),
        .o_in_ready(s_in.ready),
        .o_out_valid(m_out.valid), .i_out_ready(m_out.ready),
        .i_sts(sts), .o_cmd(cmd));

    rmt_datapath #(.MAX_CORNERS(MAX_CORNERS), .HISTORY_LEN(HISTORY_LEN)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts), .i_word(s_in.data),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_word(m_out.data));
endmodule

FILE: hdl/rmt_div.sv
// Restoring divider, one quotient bit a cycle, truncating toward zero.
// No dependencies.
module rmt_div #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic        [DEN_W-1:0] i_den,
    output logic                    o_busy,
    output logic signed [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q, n_q;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   trial;

    // shift one numerator bit into the remainder and try a subtract
    always_comb begin
        trial = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
        n_q   = {r_q[NUM_W-2:0], 1'b0};
        n_rem = trial;
        if (trial >= {1'b0, r_den}) begin
            n_rem = trial - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
            r_neg  <= i_num[NUM_W-1];
            r_q    <= i_num[NUM_W-1] ? NUM_W'(-i_num) : i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_neg ? NUM_W'(-$signed(r_q)) : $signed(r_q);
endmodule

FILE: hdl/rmt_datapath.sv
// Datapath: corner store, displacement sums, accumulators, region and history.
// Depends on rmt_pkg and rmt_div.
module rmt_datapath #(
    parameter int MAX_CORNERS = rmt_pkg::MAX_CORNERS_DEF,
    parameter int HISTORY_LEN = rmt_pkg::HISTORY_LEN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rmt_pkg::t_cmd                       i_cmd,
    output rmt_pkg::t_sts                       o_sts,
    input  rmt_pkg::t_in_word                   i_word,
    input  logic                                i_cfg_we,
    input  logic [rmt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rmt_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    output rmt_pkg::t_out_word                  o_word
);
    import rmt_pkg::*;

    localparam int AW    = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;
    localparam int CW    = $clog2(MAX_CORNERS + 1);
    localparam int HW    = $clog2(HISTORY_LEN + 1);
    localparam int SW    = COORD_W + 1 + CW;
    localparam int NW    = SW + 4;
    localparam int ACC_W = NW + 1;

    // corner memory
    logic [2*COORD_W:0] mem [MAX_CORNERS];
    logic [2*COORD_W:0] r_rd;

    logic [CW-1:0] r_count, r_good, r_ptr;
    logic signed [SW-1:0] r_sum_x, r_sum_y;
    logic signed [ACC_W-1:0] r_acc_x, r_acc_y;
    logic signed [POS_W-1:0] r_pos_x, r_pos_y;
    logic [SIZE_W-1:0] r_width, r_height;
    logic [HISTORY_LEN-1:0] r_hist;
    logic [HW-1:0] r_fill;
    logic r_ovf, r_ovf_out, r_moving, r_last;
    logic [IDX_W-1:0] r_idx;

    logic busy_x, busy_y;
    logic signed [NW-1:0] quo_x, quo_y;

    rmt_div #(.NUM_W(NW), .DEN_W(CW)) u_div_x (
        .i_clk, .i_rst_n, .i_start(i_cmd.div_start),
        .i_num(NW'({r_sum_x, 4'b0})), .i_den(r_good),
        .o_busy(busy_x), .o_quo(quo_x));
    rmt_div #(.NUM_W(NW), .DEN_W(CW)) u_div_y (
        .i_clk, .i_rst_n, .i_start(i_cmd.div_start),
        .i_num(NW'({r_sum_y, 4'b0})), .i_den(r_good),
        .o_busy(busy_y), .o_quo(quo_y));

    // accumulator update: whole part truncates toward zero
    logic signed [ACC_W-1:0] sum_acc_x, sum_acc_y, whole_x, whole_y;
    logic signed [ACC_W+1:0] np_x, np_y;
    logic signed [POS_W-1:0] sat_x, sat_y;
    logic moved;

    always_comb begin
        sum_acc_x = r_acc_x + ACC_W'(quo_x);
        sum_acc_y = r_acc_y + ACC_W'(quo_y);
        whole_x = sum_acc_x >>> 8;
        whole_y = sum_acc_y >>> 8;
        if (sum_acc_x[ACC_W-1] && sum_acc_x[7:0] != 8'd0) whole_x = whole_x + 1'b1;
        if (sum_acc_y[ACC_W-1] && sum_acc_y[7:0] != 8'd0) whole_y = whole_y + 1'b1;
        np_x = (ACC_W+2)'(r_pos_x) + (ACC_W+2)'(whole_x);
        np_y = (ACC_W+2)'(r_pos_y) + (ACC_W+2)'(whole_y);
        sat_x = (np_x > 2047) ? 12'sd2047 : (np_x < -2048) ? -12'sd2048 : POS_W'(np_x);
        sat_y = (np_y > 2047) ? 12'sd2047 : (np_y < -2048) ? -12'sd2048 : POS_W'(np_y);
        moved = (r_good != '0) && ((sat_x != r_pos_x) || (sat_y != r_pos_y));
    end

    // write and read corner memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_count < CW'(MAX_CORNERS)) begin
            mem[r_count[AW-1:0]] <= {i_word.tracked, i_word.cur_y, i_word.cur_x};
        end
        if (i_cmd.emit_rd) begin
            r_rd <= mem[r_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0; r_good <= '0; r_sum_x <= '0; r_sum_y <= '0;
            r_acc_x <= '0; r_acc_y <= '0; r_pos_x <= '0; r_pos_y <= '0;
            r_width <= SIZE_W'(64); r_height <= SIZE_W'(128);
            r_hist <= '0; r_fill <= '0; r_ovf <= 1'b0; r_ptr <= '0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_START_X: r_pos_x <= i_cfg_data;
                    REG_START_Y: r_pos_y <= i_cfg_data;
                    REG_WIDTH:   r_width <= i_cfg_data[SIZE_W-1:0];
                    REG_HEIGHT:  r_height <= i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            // accumulate one corner
            if (i_cmd.load) begin
                if (r_count < CW'(MAX_CORNERS)) begin
                    r_count <= r_count + 1'b1;
                    if (i_word.tracked) begin
                        r_good  <= r_good + 1'b1;
                        r_sum_x <= r_sum_x + SW'(i_word.cur_x) - SW'(i_word.prev_x);
                        r_sum_y <= r_sum_y + SW'(i_word.cur_y) - SW'(i_word.prev_y);
                    end
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            // apply the frame's mean motion
            if (i_cmd.update) begin
                if (r_good != '0) begin
                    r_acc_x <= sum_acc_x - (whole_x <<< 8);
                    r_acc_y <= sum_acc_y - (whole_y <<< 8);
                    r_pos_x <= sat_x;
                    r_pos_y <= sat_y;
                end
                r_hist <= HISTORY_LEN'({r_hist, moved});
                if (r_fill < HW'(HISTORY_LEN)) r_fill <= r_fill + 1'b1;
                r_moving  <= (r_fill < HW'(HISTORY_LEN - 1)) ||
                             ({r_hist, moved} & HISTORY_LEN'('1)) != '0 ;
                r_ovf_out <= r_ovf;
                r_ptr     <= '0;
            end
            if (i_cmd.emit_rd) begin
                r_idx  <= IDX_W'(r_ptr);
                r_last <= (r_ptr + 1'b1 == r_count);
            end
            if (i_cmd.emit_adv) r_ptr <= r_ptr + 1'b1;
            if (i_cmd.clear) begin
                r_count <= '0; r_good <= '0; r_sum_x <= '0; r_sum_y <= '0;
                r_ovf <= 1'b0;
            end
        end
    end

    // inside test on the registered corner
    logic signed [COORD_W-1:0] sx, sy;
    logic signed [POS_W+5:0] x0, y0, x1, y1;
    always_comb begin
        sx = r_rd[COORD_W-1:0];
        sy = r_rd[2*COORD_W-1:COORD_W];
        x0 = (POS_W+6)'(r_pos_x) <<< 4;
        y0 = (POS_W+6)'(r_pos_y) <<< 4;
        x1 = ((POS_W+6)'(r_pos_x) + (POS_W+6)'({1'b0, r_width})) <<< 4;
        y1 = ((POS_W+6)'(r_pos_y) + (POS_W+6)'({1'b0, r_height})) <<< 4;
        o_word.corner_index = r_idx;
        o_word.keep = r_rd[2*COORD_W] &&
                      (POS_W+6)'(sx) >= x0 && (POS_W+6)'(sx) < x1 &&
                      (POS_W+6)'(sy) >= y0 && (POS_W+6)'(sy) < y1;
        o_word.region_x = r_pos_x;
        o_word.region_y = r_pos_y;
        o_word.moving = r_moving;
        o_word.overflow = r_ovf_out;
        o_word.last = r_last;
    end

    assign o_sts.div_busy  = busy_x | busy_y;
    assign o_sts.emit_done = (r_ptr == r_count);
    assign o_sts.empty     = (r_count == '0);
endmodule

FILE: hdl/rmt_ctrl.sv
// Controller: sequences load, division, update and the per-corner result walk.
// Depends on rmt_pkg.
module rmt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_fend,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  rmt_pkg::t_sts i_sts,
    output rmt_pkg::t_cmd o_cmd
);
    import rmt_pkg::*;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_DIV0 = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_fend) n_state = S_DIV0;
                end
            end
            S_DIV0: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: if (!i_sts.div_busy) n_state = S_UPD;
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = S_RD;
            end
            S_RD: begin
                if (i_sts.emit_done) begin
                    o_cmd.clear = 1'b1;
                    n_state = S_LOAD;
                end else begin
                    o_cmd.emit_rd = 1'b1;
                    o_cmd.emit_adv = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.emit_done) begin
                        o_cmd.clear = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.emit_rd = 1'b1;
                        o_cmd.emit_adv = 1'b1;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

FILE: test/roi_motion_tracker_update_tb.sv
// Self-checking testbench for roi_motion_tracker_update: corner frames in, keep words out.
// Checks every result word against an in-bench region tracker model.
// Depends on rmt_pkg, rmt_stream_if and the RTL of the tracker.
module roi_motion_tracker_update_tb;
    import rmt_pkg::*;

    localparam int NCORN     = 32;
    localparam int HLEN      = 10;
    localparam int TAIL_WAIT = 60;
    localparam int WDOG_MAX  = 4000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    rmt_stream_if #(.T(t_in_word))  in_ch ();
    rmt_stream_if #(.T(t_out_word)) out_ch ();

    roi_motion_tracker_update dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_in       (in_ch),
        .m_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // tracker model state
    logic signed [POS_W-1:0]   trk_pos_x, trk_pos_y;
    logic        [SIZE_W-1:0]  trk_width, trk_height;
    logic signed [COORD_W-1:0] stored_x [NCORN];
    logic signed [COORD_W-1:0] stored_y [NCORN];
    logic                      stored_good [NCORN];
    int                        n_stored, n_good;
    longint                    acc_dx, acc_dy, frac_x, frac_y;
    logic        [HLEN-1:0]    moved_hist;
    int                        hist_fill;
    logic                      frame_ovf;

    t_out_word motion_expect_q[$];

    int  n_words, n_results, n_frames, n_fail, n_mismatch, idle_cycles;
    bit  no_idle = 1'b0;

    function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
        if (v > 2047) return 12'sd2047;
        if (v < -2048) return -12'sd2048;
        return v[POS_W-1:0];
    endfunction

    function automatic void reset_tracker();
        trk_pos_x = '0; trk_pos_y = '0;
        trk_width = 11'd64; trk_height = 11'd128;
        n_stored = 0; n_good = 0; acc_dx = 0; acc_dy = 0;
        frac_x = 0; frac_y = 0; moved_hist = '0; hist_fill = 0; frame_ovf = 1'b0;
    endfunction

    function automatic void write_tracker_reg(logic [CFG_IDX_W-1:0] idx,
                                              logic [CFG_DAT_W-1:0] val);
        case (idx)
            REG_START_X: trk_pos_x = val;
            REG_START_Y: trk_pos_y = val;
            REG_WIDTH:   trk_width = val[SIZE_W-1:0];
            REG_HEIGHT:  trk_height = val[SIZE_W-1:0];
            default: ;
        endcase
    endfunction

    // Take one corner word, queue result words on frame end
    function automatic void track_corner(t_in_word w);
        logic signed [POS_W-1:0] old_x, old_y;
        longint whole, x0, y0, x1, y1;
        logic moved, moving;
        t_out_word r;
        moved = 1'b0;
        if (n_stored < NCORN) begin
            stored_x[n_stored] = w.cur_x;
            stored_y[n_stored] = w.cur_y;
            stored_good[n_stored] = w.tracked;
            n_stored++;
            if (w.tracked) begin
                acc_dx += longint'(w.cur_x) - longint'(w.prev_x);
                acc_dy += longint'(w.cur_y) - longint'(w.prev_y);
                n_good++;
            end
        end else begin
            frame_ovf = 1'b1;
        end
        if (!w.frame_end) return;
        if (n_good > 0) begin
            old_x = trk_pos_x; old_y = trk_pos_y;
            frac_x += (acc_dx * 16) / n_good;
            frac_y += (acc_dy * 16) / n_good;
            whole = frac_x / 256; frac_x -= whole * 256;
            trk_pos_x = clamp_pos(longint'(trk_pos_x) + whole);
            whole = frac_y / 256; frac_y -= whole * 256;
            trk_pos_y = clamp_pos(longint'(trk_pos_y) + whole);
            moved = (trk_pos_x != old_x) || (trk_pos_y != old_y);
        end
        moved_hist = {moved_hist[HLEN-2:0], moved};
        if (hist_fill < HLEN) hist_fill++;
        moving = (hist_fill < HLEN) || (moved_hist != '0);
        x0 = longint'(trk_pos_x) * 16; y0 = longint'(trk_pos_y) * 16;
        x1 = (longint'(trk_pos_x) + trk_width) * 16;
        y1 = (longint'(trk_pos_y) + trk_height) * 16;
        for (int i = 0; i < n_stored; i++) begin
            r.corner_index = i[IDX_W-1:0];
            r.keep = stored_good[i] && stored_x[i] >= x0 && stored_x[i] < x1
                     && stored_y[i] >= y0 && stored_y[i] < y1;
            r.region_x = trk_pos_x;
            r.region_y = trk_pos_y;
            r.moving = moving;
            r.overflow = frame_ovf;
            r.last = (i + 1 == n_stored);
            motion_expect_q.insert(motion_expect_q.size(), r);
        end
        n_frames++;
        n_stored = 0; n_good = 0; acc_dx = 0; acc_dy = 0; frame_ovf = 1'b0;
    endfunction

    function automatic void report_mismatch(string what, t_out_word e, t_out_word a);
        n_fail++;
        n_mismatch++;
        if (n_mismatch <= 10) begin
            $write("mismatch %s: exp idx=%0d keep=%b rx=%0d ry=%0d mov=%b ovf=%b last=%b",
                   what, e.corner_index, e.keep, e.region_x, e.region_y, e.moving,
                   e.overflow, e.last);
            $display(" | got idx=%0d keep=%b rx=%0d ry=%0d mov=%b ovf=%b last=%b",
                     a.corner_index, a.keep, a.region_x, a.region_y,
                     a.moving, a.overflow, a.last);
        end
    endfunction

    // Model accepted input words; check accepted result words
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            track_corner(in_ch.data);
            n_words++;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_results++;
            if (motion_expect_q.size() == 0) begin
                n_fail++;
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result word idx=%0d", out_ch.data.corner_index);
            end else if (motion_expect_q[0] != out_ch.data) begin
                report_mismatch("result", motion_expect_q[0], out_ch.data);
                void'(motion_expect_q.pop_front());
            end else begin
                void'(motion_expect_q.pop_front());
            end
        end
    end

    // Sink side: random stall bursts, none near the end
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 4);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Watchdog: cycles with nothing accepted
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog: no word accepted for %0d cycles", idle_cycles);
            $display("[roi_motion_tracker_update] ERROR");
            $finish;
        end
    end

    task automatic send_word(t_in_word w);
        int gap;
        gap = (!no_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Drop valid and let the block drain before touching registers
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (motion_expect_q.size() == 0);
        repeat (TAIL_WAIT) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [CFG_DAT_W-1:0] sx, logic [CFG_DAT_W-1:0] sy,
                              logic [CFG_DAT_W-1:0] wd, logic [CFG_DAT_W-1:0] ht);
        logic [CFG_DAT_W-1:0] vals [4];
        vals = '{sx, sy, wd, ht};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= i[CFG_IDX_W-1:0];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            write_tracker_reg(i[CFG_IDX_W-1:0], vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [COORD_W-1:0] to_coord(longint v);
        return v[COORD_W-1:0];
    endfunction

    // Random corner near the region so that keep goes both ways
    function automatic t_in_word make_corner(bit fend);
        t_in_word w;
        longint cx, cy, span;
        if ($urandom_range(0, 9) == 0) begin
            w = {$urandom(), $urandom(), 2'b00};
        end else begin
            span = 16 * longint'(trk_width) + 32;
            cx = 16 * longint'(trk_pos_x) - 16 + $urandom_range(0, int'(span));
            span = 16 * longint'(trk_height) + 32;
            cy = 16 * longint'(trk_pos_y) - 16 + $urandom_range(0, int'(span));
            w.cur_x  = to_coord(cx);
            w.cur_y  = to_coord(cy);
            w.prev_x = to_coord(cx - $signed($urandom_range(0, 600)) + 300);
            w.prev_y = to_coord(cy - $signed($urandom_range(0, 600)) + 300);
        end
        w.tracked   = ($urandom_range(0, 3) != 0);
        w.frame_end = fend;
        return w;
    endfunction

    task automatic send_frame(int len);
        for (int i = 0; i < len; i++)
            send_word(make_corner(i == len - 1));
    endtask

    typedef struct {
        t_in_word  w;
        bit        chk;
        t_out_word res;
    } t_row;

    t_row corner_rows [$];

    // Append one stimulus row to the table
    function automatic void add_row(t_row row);
        corner_rows.insert(corner_rows.size(), row);
    endfunction

    initial begin
        int sent, phase_items, len;
        t_out_word typed;
        reset_tracker();
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // still tracked corner after reset: inside, no shift
        add_row('{'{16'sd160, 16'sd160, 16'sd160, 16'sd160, 1'b1, 1'b1}, 1'b1,
                  '{5'd0, 1'b1, 12'sd0, 12'sd0, 1'b1, 1'b0, 1'b1}});
        // nothing tracked: no shift, keep low
        add_row('{'{16'sd160, 16'sd160, 16'sd0, 16'sd0, 1'b0, 1'b1}, 1'b1,
                  '{5'd0, 1'b0, 12'sd0, 12'sd0, 1'b1, 1'b0, 1'b1}});
        // extremes of every field, region pushed to saturation
        add_row('{'{16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff, 1'b1, 1'b0}, 1'b0, '0});
        add_row('{'{16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff, 1'b1, 1'b0}, 1'b0, '0});
        add_row('{'{-16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000, 1'b0, 1'b1}, 1'b0, '0});
        add_row('{'{-16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000, 1'b1, 1'b1}, 1'b0, '0});
        add_row('{'{-16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000, 1'b1, 1'b1}, 1'b0, '0});
        // shifts with sub-pixel parts that add up in the fraction
        for (int i = 0; i < 6; i++)
            add_row('{'{16'sd40, -16'sd40, 16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b0, '0});
        add_row('{'{-16'sd9, 16'sd5, 16'sd0, 16'sd0, 1'b1, 1'b0}, 1'b0, '0});
        add_row('{'{16'sd3, -16'sd7, 16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b0, '0});

        foreach (corner_rows[k]) begin
            if (corner_rows[k].chk) begin
                // typed value must agree with the model of the block
                typed = corner_rows[k].res;
                send_word(corner_rows[k].w);
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                if (motion_expect_q.size() == 0 || motion_expect_q[$] != typed)
                    report_mismatch("table", typed, motion_expect_q[$]);
            end else begin
                send_word(corner_rows[k].w);
            end
        end
        wait_drained();

        // too many corners in one frame
        write_regs(12'd0, 12'd0, 12'd64, 12'd128);
        send_frame(NCORN + 3);
        wait_drained();

        // register settings: extremes, zero size, full size, reset defaults, random
        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_regs(12'h800, 12'h7ff, 12'd0, 12'd0);
                1: write_regs(12'h7ff, 12'h800, 12'd2047, 12'd2047);
                2: write_regs(12'd0, 12'd0, 12'd64, 12'd128);
                default: write_regs(CFG_DAT_W'($urandom_range(0, 4095)),
                                    CFG_DAT_W'($urandom_range(0, 4095)),
                                    CFG_DAT_W'($urandom_range(0, 2047)),
                                    CFG_DAT_W'($urandom_range(0, 2047)));
            endcase
            phase_items = 0;
            while (phase_items < 50) begin
                if (sent > 170) no_idle = 1'b1;
                len = ($urandom_range(0, 11) == 0) ? $urandom_range(NCORN, NCORN + 4)
                                                   : $urandom_range(1, 8);
                send_frame(len);
                phase_items += len;
                sent += len;
            end
            wait_drained();
        end

        $display("run covered %0d corner words in %0d frames, %0d result words checked",
                 n_words, n_frames, n_results);
        $display("register phases: extremes, zero and full size, random; %0d mismatches",
                 n_fail);
        if (n_fail == 0 && motion_expect_q.size() == 0)
            $display("[roi_motion_tracker_update] OK");
        else
            $display("[roi_motion_tracker_update] ERROR");
        $finish;
    end

endmodule

FILE: files.f
hdl/rmt_pkg.sv
hdl/rmt_stream_if.sv
hdl/rmt_div.sv
hdl/rmt_datapath.sv
hdl/rmt_ctrl.sv
hdl/roi_motion_tracker_update.sv
test/roi_motion_tracker_update_tb.sv
